// File: rtl/core/htc_pkg.sv
// Shared types, constants and point-field helpers for the Hermite tone curve.
package htc_pkg;

	localparam int CODE_W     = 16;
	localparam int SLOPE_W    = 24;
	localparam int PT_IDX_W   = 3;
	localparam int PTS_W      = 256;
	localparam int TQ_W       = 17;
	localparam int DIV_STAGES = 17;
	localparam int BASIS_W    = 20;
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;

	// register indexes (paddr[5:3])
	localparam logic [2:0] REG_INPUT_MIN   = 3'd0;
	localparam logic [2:0] REG_INV_RANGE   = 3'd1;
	localparam logic [2:0] REG_POINT_COUNT = 3'd2;
	localparam logic [2:0] REG_POINTS_A    = 3'd3;
	localparam logic [2:0] REG_POINTS_B    = 3'd4;
	localparam logic [2:0] REG_POINTS_C    = 3'd5;
	localparam logic [2:0] REG_POINTS_D    = 3'd6;

	localparam logic [15:0]      RST_INPUT_MIN   = 16'd0;
	localparam logic [32:0]      RST_INV_RANGE   = 33'd65536;
	localparam logic [3:0]       RST_POINT_COUNT = 4'd2;
	localparam logic [PTS_W-1:0] RST_POINTS      = {192'h0, 64'hFFFF_FFFF_0000_0000};

	localparam logic [31:0]        SLOPE_POS_MAX = 32'd8388607;
	localparam logic [31:0]        SLOPE_NEG_MAG = 32'd8388608;
	localparam logic [SLOPE_W-1:0] SLOPE_POS_SAT = 24'h7F_FFFF;
	localparam logic [SLOPE_W-1:0] SLOPE_NEG_SAT = 24'h80_0000;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_LOAD,
		ENG_DIV,
		ENG_STORE
	} htc_eng_state_t;

	typedef struct packed {
		logic                      we;
		logic [PT_IDX_W-1:0]       addr;
		logic signed [SLOPE_W-1:0] data;
	} htc_tan_wr_t;

	typedef struct packed {
		logic                      hold;
		logic                      err;
		logic [CODE_W-1:0]         yh;
		logic [CODE_W-1:0]         y0;
		logic [CODE_W-1:0]         y1;
		logic [CODE_W-1:0]         h;
		logic signed [SLOPE_W-1:0] m0;
		logic signed [SLOPE_W-1:0] m1;
	} htc_ctx_t;

	typedef struct packed {
		htc_ctx_t          ctx;
		logic [CODE_W-1:0] rem;
		logic [TQ_W-1:0]   q;
	} htc_div_t;

	function automatic logic [CODE_W-1:0] pt_x(input logic [PTS_W-1:0] pts,
		input logic [PT_IDX_W-1:0] k);
		pt_x = pts[{k, 5'd0} +: CODE_W];
	endfunction

	function automatic logic [CODE_W-1:0] pt_y(input logic [PTS_W-1:0] pts,
		input logic [PT_IDX_W-1:0] k);
		pt_y = pts[{k, 5'd16} +: CODE_W];
	endfunction

endpackage

// File: rtl/core/htc_tangent_engine.sv
// Sequential Catmull-Rom tangent builder: one shared bit-serial divider.
module htc_tangent_engine #(
	parameter int MAX_POINTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         kick,
	input  logic [3:0]                   point_count,
	input  logic [htc_pkg::PTS_W-1:0]    points,
	output logic                         busy,
	output htc_pkg::htc_tan_wr_t         tan_wr
);

	localparam int KW = $clog2(MAX_POINTS);
	localparam logic [KW-1:0] K_LAST = KW'(MAX_POINTS - 1);

	htc_pkg::htc_eng_state_t state_q, state_d;
	logic [KW-1:0]  k_q;
	logic [4:0]     cnt_q;
	logic [31:0]    num_q;
	logic [15:0]    rem_q;
	logic [15:0]    dvs_q;
	logic           neg_q;
	logic           zero_q;

	logic [3:0]     k4;
	logic [2:0]     ia, ib;
	logic [16:0]    dy, dx;
	logic [15:0]    mag_dy;
	logic [16:0]    trial;
	logic signed [htc_pkg::SLOPE_W-1:0] tan_val;

	// slope pair for tangent k
	always_comb begin
		k4 = 4'(k_q);
		if (k4 == 4'd0) begin
			ia = 3'd0;
			ib = 3'd1;
		end else if (k4 == point_count - 4'd1) begin
			ia = 3'(point_count - 4'd2);
			ib = 3'(point_count - 4'd1);
		end else begin
			ia = 3'(k4 - 4'd1);
			ib = 3'(k4 + 4'd1);
		end
		dy = {1'b0, htc_pkg::pt_y(points, ib)} - {1'b0, htc_pkg::pt_y(points, ia)};
		dx = {1'b0, htc_pkg::pt_x(points, ib)} - {1'b0, htc_pkg::pt_x(points, ia)};
		mag_dy = dy[16] ? 16'(-dy) : dy[15:0];
		trial = {rem_q, num_q[31]};
	end

	always_comb begin
		if (zero_q) begin
			tan_val = '0;
		end else if (neg_q) begin
			tan_val = (num_q > htc_pkg::SLOPE_NEG_MAG) ? htc_pkg::SLOPE_NEG_SAT
				: htc_pkg::SLOPE_W'(-num_q);
		end else begin
			tan_val = (num_q > htc_pkg::SLOPE_POS_MAX) ? htc_pkg::SLOPE_POS_SAT
				: num_q[htc_pkg::SLOPE_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		tan_wr = '0;
		busy = (state_q != htc_pkg::ENG_IDLE);
		case (state_q)
			htc_pkg::ENG_IDLE: begin
				state_d = htc_pkg::ENG_IDLE;
			end
			htc_pkg::ENG_LOAD: begin
				state_d = htc_pkg::ENG_DIV;
			end
			htc_pkg::ENG_DIV: begin
				if (cnt_q == 5'd31)
					state_d = htc_pkg::ENG_STORE;
			end
			htc_pkg::ENG_STORE: begin
				tan_wr.we = 1'b1;
				tan_wr.addr = htc_pkg::PT_IDX_W'(k_q);
				tan_wr.data = tan_val;
				state_d = (k_q == K_LAST) ? htc_pkg::ENG_IDLE : htc_pkg::ENG_LOAD;
			end
			default: begin
				state_d = htc_pkg::ENG_IDLE;
			end
		endcase
		if (kick)
			state_d = htc_pkg::ENG_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htc_pkg::ENG_LOAD;
			k_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (kick)
				k_q <= '0;
			else if (state_q == htc_pkg::ENG_STORE && k_q != K_LAST)
				k_q <= k_q + 1'b1;
			if (state_q == htc_pkg::ENG_LOAD)
				cnt_q <= '0;
			else if (state_q == htc_pkg::ENG_DIV)
				cnt_q <= cnt_q + 5'd1;
		end
	end

	// restoring divide, quotient shifts into num_q
	always_ff @(posedge clk) begin
		if (state_q == htc_pkg::ENG_LOAD) begin
			num_q <= {mag_dy, 16'h0};
			rem_q <= '0;
			dvs_q <= dx[15:0];
			neg_q <= dy[16];
			zero_q <= dx[16] || (dx == 17'd0);
		end else if (state_q == htc_pkg::ENG_DIV) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 16'(trial - {1'b0, dvs_q});
				num_q <= {num_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				num_q <= {num_q[30:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/core/hermite_tone_curve_core.sv
// Hermite tone curve core: normalize, segment lookup, pipelined divide, spline eval.
// A request accepted at a clock edge shows its result with done high; one request
// per cycle sustained while busy is low, the receiver cannot stall.
// t comes from the 17-stage restoring divider, one quotient bit a stage.
// busy is high after reset and after every register write while the tangent engine
// rebuilds all MAX_POINTS tangents, one after another.
// Reset clears all valid bits and loads register defaults; tangent memory is rebuilt.
module hermite_tone_curve_core #(
	parameter int MAX_POINTS = 8,
	parameter int PIXEL_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               start,
	output logic                               busy,
	input  logic [15:0]                        pixel_in,
	// result channel
	output logic                               done,
	output logic [15:0]                        pixel_out,
	output logic                               clipped,
	output logic                               config_error,
	// register port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [htc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [htc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [htc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int KW = $clog2(MAX_POINTS);
	localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIXEL_BITS) - 1);

	// ---------------- configuration registers ----------------
	logic [15:0]                   input_min_q;
	logic [32:0]                   inv_range_q;
	logic [3:0]                    point_count_q;
	logic [htc_pkg::PTS_W-1:0]     points_q;
	logic                          cfg_wr;
	logic [2:0]                    cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_min_q <= htc_pkg::RST_INPUT_MIN;
			inv_range_q <= htc_pkg::RST_INV_RANGE;
			point_count_q <= htc_pkg::RST_POINT_COUNT;
			points_q <= htc_pkg::RST_POINTS;
		end else if (cfg_wr) begin
			case (cfg_idx)
				htc_pkg::REG_INPUT_MIN:   input_min_q <= pwdata[15:0];
				htc_pkg::REG_INV_RANGE:   inv_range_q <= pwdata[32:0];
				htc_pkg::REG_POINT_COUNT: point_count_q <= pwdata[3:0];
				htc_pkg::REG_POINTS_A:    points_q[63:0] <= pwdata;
				htc_pkg::REG_POINTS_B:    points_q[127:64] <= pwdata;
				htc_pkg::REG_POINTS_C:    points_q[191:128] <= pwdata;
				htc_pkg::REG_POINTS_D:    points_q[255:192] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			htc_pkg::REG_INPUT_MIN:   prdata = {48'h0, input_min_q};
			htc_pkg::REG_INV_RANGE:   prdata = {31'h0, inv_range_q};
			htc_pkg::REG_POINT_COUNT: prdata = {60'h0, point_count_q};
			htc_pkg::REG_POINTS_A:    prdata = points_q[63:0];
			htc_pkg::REG_POINTS_B:    prdata = points_q[127:64];
			htc_pkg::REG_POINTS_C:    prdata = points_q[191:128];
			htc_pkg::REG_POINTS_D:    prdata = points_q[255:192];
			default:                  prdata = '0;
		endcase
	end

	// ---------------- tangent engine and tangent memory ----------------
	htc_pkg::htc_tan_wr_t tan_wr;
	logic signed [htc_pkg::SLOPE_W-1:0] tan_mem [MAX_POINTS];

	htc_tangent_engine #(
		.MAX_POINTS (MAX_POINTS)
	) u_tan (
		.clk         (clk),
		.arst_n      (arst_n),
		.kick        (cfg_wr),
		.point_count (point_count_q),
		.points      (points_q),
		.busy        (busy),
		.tan_wr      (tan_wr)
	);

	always_ff @(posedge clk) begin
		if (tan_wr.we)
			tan_mem[tan_wr.addr[KW-1:0]] <= tan_wr.data;
	end

	// ---------------- point set decode ----------------
	logic [15:0] px [8];
	logic [15:0] py [8];
	logic        bad;
	logic [15:0] xlast, ylast;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			px[k] = htc_pkg::pt_x(points_q, 3'(k));
			py[k] = htc_pkg::pt_y(points_q, 3'(k));
		end
		bad = (point_count_q < 4'd2) || (int'(point_count_q) > MAX_POINTS);
		for (int k = 1; k < MAX_POINTS; k++) begin
			if (k < int'(point_count_q) && px[k] <= px[k-1])
				bad = 1'b1;
		end
		xlast = px[0];
		ylast = py[0];
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (k == int'(point_count_q) - 1) begin
				xlast = px[k];
				ylast = py[k];
			end
		end
	end

	// ---------------- stage 1: mask, offset ----------------
	logic        v_s1;
	logic [15:0] pix_s1;
	logic [15:0] d_s1;
	logic        dpos_s1;
	logic [15:0] pix_m;
	logic [16:0] d_full;

	assign pix_m = pixel_in & PIX_MASK;
	assign d_full = {1'b0, pix_m} - {1'b0, input_min_q};

	// ---------------- stage 2: scale ----------------
	logic        v_s2;
	logic [15:0] pix_s2;
	logic [48:0] prod_s2;

	// ---------------- stage 3: clamp to Q0.16 ----------------
	logic        v_s3;
	logic [15:0] pix_s3;
	logic [15:0] x_s3;
	logic [15:0] x_d;

	assign x_d = (|prod_s2[48:32]) ? 16'hFFFF : prod_s2[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pix_m;
		d_s1 <= d_full[15:0];
		dpos_s1 <= !d_full[16] && (d_full != 17'd0);
		pix_s2 <= pix_s1;
		prod_s2 <= dpos_s1 ? (49'(d_s1) * 49'(inv_range_q)) : '0;
		pix_s3 <= pix_s2;
		x_s3 <= x_d;
	end

	// ---------------- stage 4: segment lookup, tangent read ----------------
	logic              v_s4;
	htc_pkg::htc_ctx_t ctx_s4, ctx_d;
	logic [15:0]       a_s4, a_d;
	logic signed [htc_pkg::SLOPE_W-1:0] m0_s4, m1_s4;
	logic [KW-1:0]     seg_i;
	logic [15:0]       sx0, sx1, sy0, sy1;
	logic              left, right;

	always_comb begin
		seg_i = KW'(int'(point_count_q) - 2);
		for (int k = MAX_POINTS - 2; k >= 0; k--) begin
			if (k + 2 < int'(point_count_q) && x_s3 <= px[k+1])
				seg_i = KW'(k);
		end
		sx0 = px[0];
		sx1 = px[1];
		sy0 = py[0];
		sy1 = py[1];
		for (int k = 0; k < MAX_POINTS - 1; k++) begin
			if (KW'(k) == seg_i) begin
				sx0 = px[k];
				sx1 = px[k+1];
				sy0 = py[k];
				sy1 = py[k+1];
			end
		end
		left = (x_s3 <= px[0]);
		right = (x_s3 >= xlast);
		ctx_d.hold = bad || left || right;
		ctx_d.err = bad;
		ctx_d.yh = bad ? pix_s3 : (left ? py[0] : ylast);
		ctx_d.y0 = sy0;
		ctx_d.y1 = sy1;
		ctx_d.h = sx1 - sx0;
		ctx_d.m0 = '0;
		ctx_d.m1 = '0;
		a_d = x_s3 - sx0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		ctx_s4 <= ctx_d;
		a_s4 <= a_d;
		m0_s4 <= tan_mem[seg_i];
		m1_s4 <= tan_mem[KW'(seg_i + 1'b1)];
	end

	// ---------------- divider: t = (a << 16) / h, one bit a stage ----------------
	htc_pkg::htc_div_t div_s [htc_pkg::DIV_STAGES];
	htc_pkg::htc_div_t div_d [htc_pkg::DIV_STAGES];
	logic              div_v_s [htc_pkg::DIV_STAGES];

	always_comb begin
		htc_pkg::htc_div_t cur;
		logic [16:0]       trial;
		for (int j = 0; j < htc_pkg::DIV_STAGES; j++) begin
			if (j == 0) begin
				cur.ctx = ctx_s4;
				cur.ctx.m0 = m0_s4;
				cur.ctx.m1 = m1_s4;
				cur.rem = '0;
				cur.q = '0;
				trial = {1'b0, a_s4};
			end else begin
				cur = div_s[j-1];
				trial = {cur.rem, 1'b0};
			end
			div_d[j] = cur;
			if (trial >= {1'b0, cur.ctx.h}) begin
				div_d[j].rem = 16'(trial - {1'b0, cur.ctx.h});
				div_d[j].q = {cur.q[15:0], 1'b1};
			end else begin
				div_d[j].rem = trial[15:0];
				div_d[j].q = {cur.q[15:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < htc_pkg::DIV_STAGES; j++)
				div_v_s[j] <= 1'b0;
		end else begin
			div_v_s[0] <= v_s4;
			for (int j = 1; j < htc_pkg::DIV_STAGES; j++)
				div_v_s[j] <= div_v_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < htc_pkg::DIV_STAGES; j++)
			div_s[j] <= div_d[j];
	end

	// ---------------- spline evaluation ----------------
	logic              v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	htc_pkg::htc_ctx_t ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9, ctx_s10;
	logic [16:0]       t_s5, t2_s5, t_s6, t2_s6, t3_s6;
	logic [33:0]       tt, t2t;
	logic signed [htc_pkg::BASIS_W-1:0] tx, t2x, t3x;
	logic signed [htc_pkg::BASIS_W-1:0] h00_s7, h10_s7, h01_s7, h11_s7;
	logic signed [36:0] a10_s8, a11_s8, p0_s8, p1_s8;
	logic signed [60:0] q0_s9, q1_s9;
	logic signed [37:0] psum_s9;
	logic signed [63:0] psum_x;
	logic signed [63:0] s_s10;
	logic signed [63:0] s_rnd;
	logic signed [31:0] v_val;
	logic [15:0]        res_d;
	logic               clip_d;
	logic [16:0]        t_div;

	assign t_div = div_s[htc_pkg::DIV_STAGES-1].q;
	assign tt = 34'(t_div) * 34'(t_div);
	assign t2t = 34'(t2_s5) * 34'(t_s5);
	assign tx = $signed(htc_pkg::BASIS_W'(t_s6));
	assign t2x = $signed(htc_pkg::BASIS_W'(t2_s6));
	assign t3x = $signed(htc_pkg::BASIS_W'(t3_s6));
	assign psum_x = psum_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s5 <= div_v_s[htc_pkg::DIV_STAGES-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		// t^2
		ctx_s5 <= div_s[htc_pkg::DIV_STAGES-1].ctx;
		t_s5 <= t_div;
		t2_s5 <= tt[32:16];
		// t^3
		ctx_s6 <= ctx_s5;
		t_s6 <= t_s5;
		t2_s6 <= t2_s5;
		t3_s6 <= t2t[32:16];
		// Hermite basis
		ctx_s7 <= ctx_s6;
		h00_s7 <= (t3x <<< 1) - (t2x + (t2x <<< 1)) + 20'sd65536;
		h10_s7 <= t3x - (t2x <<< 1) + tx;
		h01_s7 <= (t2x + (t2x <<< 1)) - (t3x <<< 1);
		h11_s7 <= t3x - t2x;
		// basis times span and end values
		ctx_s8 <= ctx_s7;
		a10_s8 <= h10_s7 * $signed({1'b0, ctx_s7.h});
		a11_s8 <= h11_s7 * $signed({1'b0, ctx_s7.h});
		p0_s8 <= h00_s7 * $signed({1'b0, ctx_s7.y0});
		p1_s8 <= h01_s7 * $signed({1'b0, ctx_s7.y1});
		// tangent terms
		ctx_s9 <= ctx_s8;
		q0_s9 <= a10_s8 * ctx_s8.m0;
		q1_s9 <= a11_s8 * ctx_s8.m1;
		psum_s9 <= p0_s8 + p1_s8;
		// sum at scale 2^32
		ctx_s10 <= ctx_s9;
		s_s10 <= (psum_x <<< 16) + q0_s9 + q1_s9;
	end

	// round half up to Q0.16, then saturate
	always_comb begin
		s_rnd = s_s10 + 64'sd2147483648;
		v_val = s_rnd[63:32];
		if (ctx_s10.hold) begin
			res_d = ctx_s10.yh;
			clip_d = 1'b0;
		end else if (v_val < 32'sd0) begin
			res_d = 16'h0;
			clip_d = 1'b1;
		end else if (v_val > 32'sd65535) begin
			res_d = 16'hFFFF;
			clip_d = 1'b1;
		end else begin
			res_d = v_val[15:0];
			clip_d = 1'b0;
		end
	end

	// ---------------- result register ----------------
	logic        done_q;
	logic [15:0] pixel_out_q;
	logic        clipped_q;
	logic        config_error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= v_s10;
	end

	always_ff @(posedge clk) begin
		pixel_out_q <= res_d;
		clipped_q <= clip_d;
		config_error_q <= ctx_s10.err;
	end

	assign done = done_q;
	assign pixel_out = pixel_out_q;
	assign clipped = clipped_q;
	assign config_error = config_error_q;

endmodule
